// ===== src/tnc_pkg.sv =====
`default_nettype none
package tnc_pkg;

  localparam int CoordW     = 24;
  localparam int CoordFrac  = 8;
  localparam int NormFrac   = 14;
  localparam int AreaW      = 24;
  localparam int Lanes      = 3;

  localparam int EdgeW      = CoordW + 1;
  localparam int SumW       = CoordW + 2;
  localparam int AbsW       = SumW - 1;
  localparam int ProdW      = 2 * EdgeW;
  localparam int CrossW     = ProdW + 1;
  localparam int MagW       = ProdW;
  localparam int HalfW      = MagW / 2;
  localparam int Mag2W      = 2 * MagW;
  localparam int SqW        = Mag2W + 2;
  localparam int RemW       = SqW + 1;
  localparam int AreaSqW    = 2 * AreaW;
  localparam int LimShift   = 2 + 2 * CoordFrac;
  localparam int LimW       = AreaSqW + LimShift;

  localparam int QuoW       = 2 * NormFrac + 3;
  localparam int RootW      = (QuoW + 1) / 2;
  localparam int RadW       = 2 * RootW;
  localparam int SrW        = RootW + 2;
  localparam int NormW      = NormFrac + 2;

  // floor(a / 3) = (a * ceil(2^27 / 3)) >> 27, exact for a < 2^25
  localparam int RecipW     = 26;
  localparam int RecipShift = 27;
  localparam logic [RecipW-1:0] Recip3 = 26'd44739243;
  localparam int CprodW     = AbsW + RecipW;

  typedef enum logic [0:0] {
    RegDegArea = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] centroid_x;
    logic signed [CoordW-1:0] centroid_y;
    logic signed [CoordW-1:0] centroid_z;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic                     is_degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] centroid_x;
    logic signed [CoordW-1:0] centroid_y;
    logic signed [CoordW-1:0] centroid_z;
    logic [Lanes-1:0]         neg;
    logic                     zero;
    logic                     degenerate;
  } side_t;

endpackage
`default_nettype wire

// ===== src/triangle_normal_centroid_degenerate_unit.sv =====
`default_nettype none
// stages: 7 front, 31 divider, 16 square root, then the output register
// throughput: one triangle per cycle while the skid stage is empty; the 31-stage
// quotient pipeline is the deepest part
// reset: all valid bits clear, degenerate_area clears to zero, no items in flight
module triangle_normal_centroid_degenerate_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tnc_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tnc_pkg::out_item_t      out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import tnc_pkg::*;

  logic [AreaW-1:0]   area_q;
  logic [AreaSqW-1:0] area_sq_q;

  logic               en;
  logic               fr_valid;
  logic [Mag2W-1:0]   fr_mag2 [Lanes];
  logic [SqW-1:0]     fr_sq;
  side_t              fr_side;
  logic               dv_valid;
  logic [QuoW-1:0]    dv_quo [Lanes];
  side_t              dv_side;
  logic               sr_valid;
  logic [RootW-1:0]   sr_root [Lanes];
  side_t              sr_side;

  logic [RootW:0]     kinc [Lanes];
  logic [NormW-1:0]   kmag [Lanes];
  logic signed [NormW-1:0] norm [Lanes];
  out_item_t          res;

  logic               out_valid_q, skid_valid_q;
  out_item_t          out_q, skid_q;
  logic               out_take;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      RegDegArea: prdata = 32'(area_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q    <= '0;
      area_sq_q <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == RegDegArea)) begin
        area_q <= pwdata[AreaW-1:0];
      end
      area_sq_q <= area_q * area_q;
    end
  end

  // whole pipeline moves unless the skid stage holds an item
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  tnc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .area_sq_i  (area_sq_q),
    .valid_o    (fr_valid),
    .mag2_o     (fr_mag2),
    .sq_o       (fr_sq),
    .side_o     (fr_side)
  );

  tnc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .mag2_i  (fr_mag2),
    .sq_i    (fr_sq),
    .side_i  (fr_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  tnc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .quo_i   (dv_quo),
    .side_i  (dv_side),
    .valid_o (sr_valid),
    .root_o  (sr_root),
    .side_o  (sr_side)
  );

  // largest k with (2k-1)^2 <= q is (isqrt(q) + 1) / 2
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      kinc[l] = (RootW + 1)'(sr_root[l]) + (RootW + 1)'(1);
      kmag[l] = NormW'(kinc[l][RootW:1]);
      if (sr_side.zero) begin
        norm[l] = '0;
      end else if (sr_side.neg[l]) begin
        norm[l] = -$signed(kmag[l]);
      end else begin
        norm[l] = $signed(kmag[l]);
      end
    end
    res.centroid_x    = sr_side.centroid_x;
    res.centroid_y    = sr_side.centroid_y;
    res.centroid_z    = sr_side.centroid_z;
    res.normal_x      = norm[0];
    res.normal_y      = norm[1];
    res.normal_z      = norm[2];
    res.is_degenerate = sr_side.degenerate;
  end

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en && sr_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && sr_valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.normal_x <= 16'sd16384 && out_item_o.normal_x >= -16'sd16384
                  && out_item_o.normal_y <= 16'sd16384 && out_item_o.normal_y >= -16'sd16384
                  && out_item_o.normal_z <= 16'sd16384 && out_item_o.normal_z >= -16'sd16384))
    else $error("normal component out of unit range");

  a_normal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.is_degenerate) |->
      (out_item_o.normal_x != 0 || out_item_o.normal_y != 0 || out_item_o.normal_z != 0))
    else $error("non-degenerate triangle with zero normal");

endmodule
`default_nettype wire

// ===== src/tnc_front.sv =====
`default_nettype none
module tnc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          in_valid_i,
  input  wire tnc_pkg::in_item_t             in_item_i,
  input  wire logic [tnc_pkg::AreaSqW-1:0]   area_sq_i,
  output logic                               valid_o,
  output logic [tnc_pkg::Mag2W-1:0]          mag2_o [tnc_pkg::Lanes],
  output logic [tnc_pkg::SqW-1:0]            sq_o,
  output tnc_pkg::side_t                     side_o
);
  import tnc_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  // stage 1: edges and coordinate sums
  logic signed [EdgeW-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [SumW-1:0]  sum_q [Lanes];
  // stage 2: cross products and centroid reciprocal multiply
  logic signed [ProdW-1:0] pa_q [Lanes];
  logic signed [ProdW-1:0] pb_q [Lanes];
  logic [CprodW-1:0]       cprod_q [Lanes];
  logic [Lanes-1:0]        cneg_q;
  // stage 3
  logic [MagW-1:0]         mag_q [Lanes];
  side_t                   s3_q;
  // stage 4
  logic [2*HalfW-1:0]      hh_q [Lanes];
  logic [2*HalfW-1:0]      hl_q [Lanes];
  logic [2*HalfW-1:0]      ll_q [Lanes];
  side_t                   s4_q;
  // stage 5
  logic [Mag2W-1:0]        m5_q [Lanes];
  side_t                   s5_q;
  // stage 6
  logic [Mag2W-1:0]        m6_q [Lanes];
  logic [SqW-1:0]          sq6_q;
  side_t                   s6_q;
  // stage 7
  logic [Mag2W-1:0]        m7_q [Lanes];
  logic [SqW-1:0]          sq7_q;
  side_t                   s7_q;

  logic signed [EdgeW-1:0] ux_d, uy_d, uz_d, wx_d, wy_d, wz_d;
  logic signed [SumW-1:0]  sum_d [Lanes];
  logic signed [ProdW-1:0] pa_d [Lanes];
  logic signed [ProdW-1:0] pb_d [Lanes];
  logic [CprodW-1:0]       cprod_d [Lanes];
  logic [AbsW-1:0]         cabs [Lanes];
  logic signed [CrossW-1:0] xprod [Lanes];
  logic [MagW-1:0]         mag_d [Lanes];
  logic [CoordW-1:0]       cquo [Lanes];
  logic signed [CoordW-1:0] cent [Lanes];
  logic [Lanes-1:0]        neg_d;
  logic [Mag2W-1:0]        m5_d [Lanes];
  logic [SqW-1:0]          sq6_d;
  logic [LimW-1:0]         lim;
  side_t                   s7_d;

  always_comb begin
    ux_d = EdgeW'(in_item_i.v1_x) - EdgeW'(in_item_i.v0_x);
    uy_d = EdgeW'(in_item_i.v1_y) - EdgeW'(in_item_i.v0_y);
    uz_d = EdgeW'(in_item_i.v1_z) - EdgeW'(in_item_i.v0_z);
    wx_d = EdgeW'(in_item_i.v2_x) - EdgeW'(in_item_i.v0_x);
    wy_d = EdgeW'(in_item_i.v2_y) - EdgeW'(in_item_i.v0_y);
    wz_d = EdgeW'(in_item_i.v2_z) - EdgeW'(in_item_i.v0_z);
    sum_d[0] = SumW'(in_item_i.v0_x) + SumW'(in_item_i.v1_x) + SumW'(in_item_i.v2_x);
    sum_d[1] = SumW'(in_item_i.v0_y) + SumW'(in_item_i.v1_y) + SumW'(in_item_i.v2_y);
    sum_d[2] = SumW'(in_item_i.v0_z) + SumW'(in_item_i.v1_z) + SumW'(in_item_i.v2_z);
  end

  always_comb begin
    pa_d[0] = uy_q * wz_q;
    pb_d[0] = uz_q * wy_q;
    pa_d[1] = uz_q * wx_q;
    pb_d[1] = ux_q * wz_q;
    pa_d[2] = ux_q * wy_q;
    pb_d[2] = uy_q * wx_q;
    for (int i = 0; i < Lanes; i++) begin
      cabs[i]    = AbsW'(sum_q[i][SumW-1] ? -sum_q[i] : sum_q[i]);
      cprod_d[i] = CprodW'(cabs[i]) * CprodW'(Recip3);
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      xprod[i] = CrossW'(pa_q[i]) - CrossW'(pb_q[i]);
      neg_d[i] = xprod[i][CrossW-1];
      mag_d[i] = MagW'(neg_d[i] ? -xprod[i] : xprod[i]);
      cquo[i]  = cprod_q[i][CprodW-1:RecipShift];
      cent[i]  = cneg_q[i] ? -$signed(cquo[i]) : $signed(cquo[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      m5_d[i] = (Mag2W'(hh_q[i]) << (2 * HalfW)) + (Mag2W'(hl_q[i]) << (HalfW + 1))
              + Mag2W'(ll_q[i]);
    end
    sq6_d = SqW'(m5_q[0]) + SqW'(m5_q[1]) + SqW'(m5_q[2]);
    lim   = {area_sq_i, {LimShift{1'b0}}};
    s7_d            = s6_q;
    s7_d.zero       = (sq6_q == '0);
    s7_d.degenerate = (sq6_q <= SqW'(lim));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= ux_d;
      uy_q <= uy_d;
      uz_q <= uz_d;
      wx_q <= wx_d;
      wy_q <= wy_d;
      wz_q <= wz_d;
      for (int i = 0; i < Lanes; i++) begin
        sum_q[i]   <= sum_d[i];
        pa_q[i]    <= pa_d[i];
        pb_q[i]    <= pb_d[i];
        cprod_q[i] <= cprod_d[i];
        cneg_q[i]  <= sum_q[i][SumW-1];
        mag_q[i]   <= mag_d[i];
        hh_q[i]    <= mag_q[i][MagW-1:HalfW] * mag_q[i][MagW-1:HalfW];
        hl_q[i]    <= mag_q[i][MagW-1:HalfW] * mag_q[i][HalfW-1:0];
        ll_q[i]    <= mag_q[i][HalfW-1:0] * mag_q[i][HalfW-1:0];
        m5_q[i]    <= m5_d[i];
        m6_q[i]    <= m5_q[i];
        m7_q[i]    <= m6_q[i];
      end
      s3_q.centroid_x <= cent[0];
      s3_q.centroid_y <= cent[1];
      s3_q.centroid_z <= cent[2];
      s3_q.neg        <= neg_d;
      s3_q.zero       <= 1'b0;
      s3_q.degenerate <= 1'b0;
      s4_q  <= s3_q;
      s5_q  <= s4_q;
      s6_q  <= s5_q;
      sq6_q <= sq6_d;
      sq7_q <= sq6_q;
      s7_q  <= s7_d;
    end
  end

  assign valid_o = v7_q;
  assign mag2_o  = m7_q;
  assign sq_o    = sq7_q;
  assign side_o  = s7_q;

endmodule
`default_nettype wire

// ===== src/tnc_div.sv =====
`default_nettype none
module tnc_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [tnc_pkg::Mag2W-1:0]     mag2_i [tnc_pkg::Lanes],
  input  wire logic [tnc_pkg::SqW-1:0]       sq_i,
  input  wire tnc_pkg::side_t                side_i,
  output logic                               valid_o,
  output logic [tnc_pkg::QuoW-1:0]           quo_o [tnc_pkg::Lanes],
  output tnc_pkg::side_t                     side_o
);
  import tnc_pkg::*;

  // one quotient bit per stage, restoring, msb first
  logic            vld_q  [QuoW];
  logic [RemW-1:0] rem_q  [QuoW][Lanes];
  logic [QuoW-1:0] quo_q  [QuoW][Lanes];
  logic [SqW-1:0]  sq_q   [QuoW];
  side_t           side_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic            vld_in;
    logic [SqW-1:0]  sq_in;
    side_t           side_in;
    logic [RemW-1:0] rin  [Lanes];
    logic [QuoW-1:0] qin  [Lanes];
    logic [RemW-1:0] rnew [Lanes];
    logic [QuoW-1:0] qnew [Lanes];

    if (s == 0) begin : g_first
      always_comb begin
        vld_in  = valid_i;
        sq_in   = sq_i;
        side_in = side_i;
        for (int l = 0; l < Lanes; l++) begin
          rin[l] = RemW'(mag2_i[l]);
          qin[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[s-1];
        sq_in   = sq_q[s-1];
        side_in = side_q[s-1];
        for (int l = 0; l < Lanes; l++) begin
          rin[l] = {rem_q[s-1][l][RemW-2:0], 1'b0};
          qin[l] = quo_q[s-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        if (rin[l] >= RemW'(sq_in)) begin
          rnew[l] = rin[l] - RemW'(sq_in);
          qnew[l] = {qin[l][QuoW-2:0], 1'b1};
        end else begin
          rnew[l] = rin[l];
          qnew[l] = {qin[l][QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[s]   <= sq_in;
        side_q[s] <= side_in;
        for (int l = 0; l < Lanes; l++) begin
          rem_q[s][l] <= rnew[l];
          quo_q[s][l] <= qnew[l];
        end
      end
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule
`default_nettype wire

// ===== src/tnc_sqrt.sv =====
`default_nettype none
module tnc_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [tnc_pkg::QuoW-1:0]      quo_i [tnc_pkg::Lanes],
  input  wire tnc_pkg::side_t                side_i,
  output logic                               valid_o,
  output logic [tnc_pkg::RootW-1:0]          root_o [tnc_pkg::Lanes],
  output tnc_pkg::side_t                     side_o
);
  import tnc_pkg::*;

  // digit-by-digit integer square root, one root bit per stage
  logic             vld_q  [RootW];
  logic [RadW-1:0]  rad_q  [RootW][Lanes];
  logic [SrW-1:0]   rem_q  [RootW][Lanes];
  logic [RootW-1:0] root_q [RootW][Lanes];
  side_t            side_q [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic             vld_in;
    side_t            side_in;
    logic [RadW-1:0]  rad_in  [Lanes];
    logic [SrW-1:0]   rem_in  [Lanes];
    logic [RootW-1:0] root_in [Lanes];
    logic [SrW-1:0]   shifted [Lanes];
    logic [SrW-1:0]   trial   [Lanes];
    logic [SrW-1:0]   rnew    [Lanes];
    logic [RootW-1:0] qnew    [Lanes];

    if (s == 0) begin : g_first
      always_comb begin
        vld_in  = valid_i;
        side_in = side_i;
        for (int l = 0; l < Lanes; l++) begin
          rad_in[l]  = RadW'(quo_i[l]);
          rem_in[l]  = '0;
          root_in[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[s-1];
        side_in = side_q[s-1];
        for (int l = 0; l < Lanes; l++) begin
          rad_in[l]  = rad_q[s-1][l];
          rem_in[l]  = rem_q[s-1][l];
          root_in[l] = root_q[s-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        shifted[l] = {rem_in[l][RootW-1:0], rad_in[l][RadW-1-2*s -: 2]};
        trial[l]   = {root_in[l], 2'b01};
        if (shifted[l] >= trial[l]) begin
          rnew[l] = shifted[l] - trial[l];
          qnew[l] = {root_in[l][RootW-2:0], 1'b1};
        end else begin
          rnew[l] = shifted[l];
          qnew[l] = {root_in[l][RootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        for (int l = 0; l < Lanes; l++) begin
          rad_q[s][l]  <= rad_in[l];
          rem_q[s][l]  <= rnew[l];
          root_q[s][l] <= qnew[l];
        end
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule
`default_nettype wire
